FILE: hw/rtl/vucrf_pkg.sv
// ----------------------------------------------------------------------------
// vucrf_pkg: shared types and constants of the picture unit register file
// Event codes, register port numbers and the fixed field widths and masks.
// ----------------------------------------------------------------------------
package vucrf_pkg;

  // Event carried by one request.
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_VBLANK = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Processor-visible register ports.
  typedef enum logic [2:0] {
    PORT_CTRL0    = 3'd0,
    PORT_CTRL1    = 3'd1,
    PORT_STATUS   = 3'd2,
    PORT_OAM_ADDR = 3'd3,
    PORT_OAM_DATA = 3'd4,
    PORT_SCROLL   = 3'd5,
    PORT_ADDR     = 3'd6,
    PORT_DATA     = 3'd7
  } port_t;

  localparam int OAM_BYTES_DEF = 256;
  localparam int VADDR_W       = 15;

  localparam logic [VADDR_W-1:0] STEP_ROW = VADDR_W'(32);
  localparam logic [VADDR_W-1:0] STEP_COL = VADDR_W'(1);

  localparam logic [5:0] PALETTE_PAGE      = 6'h3F;
  localparam logic [7:0] OAM_BLANK         = 8'hFF;
  localparam logic [7:0] LATCH_LOW_MASK    = 8'h1F;
  localparam logic [7:0] STATUS_SEC_MASK   = 8'hC0;
  localparam logic [7:0] STATUS_KEEP_MASK  = 8'h60;
  localparam logic [7:0] STATUS_CLEAR_MASK = 8'h1F;
  localparam logic [7:0] STATUS_VBLANK     = 8'h80;

endpackage

FILE: hw/rtl/vucrf_oam.sv
// ----------------------------------------------------------------------------
// vucrf_oam: sprite attribute memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vucrf_oam #(
  parameter int DEPTH = vucrf_pkg::OAM_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/video_unit_cpu_register_file.sv
// ----------------------------------------------------------------------------
// video_unit_cpu_register_file: processor-side register file of the picture unit
// A request passes from the input register into the result register once that one is empty or being taken.
// Throughput: one request per cycle while results are taken; input and result registers each hold one.
// Reset clears configuration, block state and valid flags; sprite memory stays undefined until written.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_file #(
  parameter int OAM_BYTES = vucrf_pkg::OAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic        in_rendering,
  input  logic [7:0]  in_vram_rdata,
  input  logic [7:0]  in_vram_mirror_rdata,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [14:0] out_vram_address_out,
  output logic        out_vram_write_enable,
  output logic [14:0] out_vram_write_address,
  output logic [7:0]  out_vram_write_data,
  output logic [14:0] out_scroll_latch,
  output logic [2:0]  out_fine_x_scroll,
  output logic [7:0]  out_control_zero,
  output logic [7:0]  out_control_one,
  output logic [7:0]  out_status_byte,
  output logic        out_vblank_interrupt
);

  localparam int PTR_W = $clog2(OAM_BYTES);
  localparam int VW    = vucrf_pkg::VADDR_W;

  // configuration
  logic [7:0] security_r;

  // input register
  logic                in_valid_r;
  vucrf_pkg::func_t    func_r;
  vucrf_pkg::port_t    port_r;
  logic [7:0]          data_r;
  logic                rendering_r;
  logic [7:0]          vrd_r;
  logic [7:0]          vmrd_r;

  // block state
  logic [7:0]       ctrl_a_r, ctrl_a_nxt;
  logic [7:0]       ctrl_b_r, ctrl_b_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [PTR_W-1:0] oam_ptr_r, oam_ptr_nxt;
  logic             toggle_r, toggle_nxt;
  logic [7:0]       latch_r, latch_nxt;
  logic [7:0]       rbuf_r, rbuf_nxt;
  logic [VW-1:0]    temp_r, temp_nxt;
  logic [VW-1:0]    cur_r, cur_nxt;
  logic [2:0]       fine_x_r, fine_x_nxt;

  // result register
  logic          out_valid_r;
  logic [7:0]    out_read_data_r;
  logic [VW-1:0] out_vaddr_r;
  logic          out_we_r;
  logic [VW-1:0] out_waddr_r;
  logic [7:0]    out_wdata_r;
  logic [VW-1:0] out_temp_r;
  logic [2:0]    out_fine_x_r;
  logic [7:0]    out_ctrl_a_r;
  logic [7:0]    out_ctrl_b_r;
  logic [7:0]    out_status_r;
  logic          out_irq_r;

  logic             s1_adv;
  logic             fire;
  logic             we;
  logic [VW-1:0]    waddr;
  logic [7:0]       wdata;
  logic             oam_we;
  logic [7:0]       oam_wdata;
  logic [7:0]       oam_rdata;
  vucrf_pkg::port_t port_eff;

  // ---------------------------------------------------------------- handshake
  assign s1_adv    = !out_valid_r || out_ready;
  assign fire      = in_valid_r && s1_adv;
  assign in_ready  = !in_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      security_r <= '0;
    end else if (cfg_valid) begin
      security_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r      <= vucrf_pkg::func_t'(in_func);
      port_r      <= vucrf_pkg::port_t'(in_address);
      data_r      <= in_data;
      rendering_r <= in_rendering;
      vrd_r       <= in_vram_rdata;
      vmrd_r      <= in_vram_mirror_rdata;
    end
  end

  // ---------------------------------------------------------------- event logic
  always_comb begin
    logic [VW-1:0] step;
    logic [7:0]    wr_byte;
    logic [7:0]    status_rd;

    step      = ctrl_a_r[2] ? vucrf_pkg::STEP_ROW : vucrf_pkg::STEP_COL;
    port_eff  = port_r;
    if (func_r == vucrf_pkg::FUNC_WRITE && security_r != '0 &&
        (port_r inside {vucrf_pkg::PORT_CTRL0, vucrf_pkg::PORT_CTRL1})) begin
      port_eff = vucrf_pkg::port_t'(port_r ^ 3'd1);
    end
    wr_byte   = (port_eff == vucrf_pkg::PORT_OAM_DATA && rendering_r) ?
                vucrf_pkg::OAM_BLANK : data_r;
    status_rd = (security_r != '0) ?
                ((status_r & vucrf_pkg::STATUS_SEC_MASK) | security_r) :
                (status_r | (latch_r & vucrf_pkg::LATCH_LOW_MASK));

    ctrl_a_nxt  = ctrl_a_r;
    ctrl_b_nxt  = ctrl_b_r;
    status_nxt  = status_r;
    oam_ptr_nxt = oam_ptr_r;
    toggle_nxt  = toggle_r;
    latch_nxt   = latch_r;
    rbuf_nxt    = rbuf_r;
    temp_nxt    = temp_r;
    cur_nxt     = cur_r;
    fine_x_nxt  = fine_x_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    oam_we      = 1'b0;
    oam_wdata   = wr_byte;

    if (fire) begin
      case (func_r)
        vucrf_pkg::FUNC_WRITE: begin
          latch_nxt = wr_byte;
          case (port_eff)
            vucrf_pkg::PORT_CTRL0: begin
              ctrl_a_nxt      = data_r;
              temp_nxt[11:10] = data_r[1:0];
            end
            vucrf_pkg::PORT_CTRL1: begin
              ctrl_b_nxt = data_r;
            end
            vucrf_pkg::PORT_OAM_ADDR: begin
              oam_ptr_nxt = data_r[PTR_W-1:0];
            end
            vucrf_pkg::PORT_OAM_DATA: begin
              oam_we      = 1'b1;
              oam_ptr_nxt = oam_ptr_r + PTR_W'(1);
            end
            vucrf_pkg::PORT_SCROLL: begin
              if (toggle_r) begin
                temp_nxt[9:5]   = data_r[7:3];
                temp_nxt[14:12] = data_r[2:0];
              end else begin
                temp_nxt[4:0] = data_r[7:3];
                fine_x_nxt    = data_r[2:0];
              end
              toggle_nxt = !toggle_r;
            end
            vucrf_pkg::PORT_ADDR: begin
              if (toggle_r) begin
                temp_nxt = {temp_r[VW-1:8], data_r};
                cur_nxt  = {temp_r[VW-1:8], data_r};
              end else begin
                temp_nxt = {1'b0, data_r[5:0], temp_r[7:0]};
              end
              toggle_nxt = !toggle_r;
            end
            vucrf_pkg::PORT_DATA: begin
              we      = 1'b1;
              waddr   = cur_r;
              wdata   = data_r;
              cur_nxt = cur_r + step;
            end
            default: begin
            end
          endcase
        end
        vucrf_pkg::FUNC_READ: begin
          case (port_r)
            vucrf_pkg::PORT_STATUS: begin
              latch_nxt  = status_rd;
              toggle_nxt = 1'b0;
              if (status_rd[7]) begin
                status_nxt = status_r & vucrf_pkg::STATUS_KEEP_MASK;
              end
            end
            vucrf_pkg::PORT_OAM_DATA: begin
              latch_nxt = oam_rdata;
            end
            vucrf_pkg::PORT_DATA: begin
              // palette reads bypass the buffer
              if (cur_r[13:8] == vucrf_pkg::PALETTE_PAGE) begin
                latch_nxt = vrd_r;
                rbuf_nxt  = vmrd_r;
              end else begin
                latch_nxt = rbuf_r;
                rbuf_nxt  = vrd_r;
              end
              cur_nxt = cur_r + step;
            end
            default: begin
            end
          endcase
        end
        vucrf_pkg::FUNC_VBLANK: begin
          status_nxt = status_r | vucrf_pkg::STATUS_VBLANK;
        end
        vucrf_pkg::FUNC_CLEAR: begin
          status_nxt = status_r & vucrf_pkg::STATUS_CLEAR_MASK;
        end
        default: begin
        end
      endcase
    end
  end

  // Read address follows the next pointer, so the registered byte is ready
  // for the following request; it never equals the address being written.
  vucrf_oam #(
    .DEPTH (OAM_BYTES)
  ) u_oam (
    .clk     (clk),
    .wr_en   (oam_we),
    .wr_addr (oam_ptr_r),
    .wr_data (oam_wdata),
    .rd_addr (oam_ptr_nxt),
    .rd_data (oam_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r  <= '0;
      ctrl_b_r  <= '0;
      status_r  <= '0;
      oam_ptr_r <= '0;
      toggle_r  <= 1'b0;
      latch_r   <= '0;
      rbuf_r    <= '0;
      temp_r    <= '0;
      cur_r     <= '0;
      fine_x_r  <= '0;
    end else begin
      ctrl_a_r  <= ctrl_a_nxt;
      ctrl_b_r  <= ctrl_b_nxt;
      status_r  <= status_nxt;
      oam_ptr_r <= oam_ptr_nxt;
      toggle_r  <= toggle_nxt;
      latch_r   <= latch_nxt;
      rbuf_r    <= rbuf_nxt;
      temp_r    <= temp_nxt;
      cur_r     <= cur_nxt;
      fine_x_r  <= fine_x_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data_r <= latch_nxt;
      out_vaddr_r     <= cur_nxt;
      out_we_r        <= we;
      out_waddr_r     <= waddr;
      out_wdata_r     <= wdata;
      out_temp_r      <= temp_nxt;
      out_fine_x_r    <= fine_x_nxt;
      out_ctrl_a_r    <= ctrl_a_nxt;
      out_ctrl_b_r    <= ctrl_b_nxt;
      out_status_r    <= status_nxt;
      out_irq_r       <= status_nxt[7] & ctrl_a_nxt[7];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = out_read_data_r;
  assign out_vram_address_out   = out_vaddr_r;
  assign out_vram_write_enable  = out_we_r;
  assign out_vram_write_address = out_waddr_r;
  assign out_vram_write_data    = out_wdata_r;
  assign out_scroll_latch       = out_temp_r;
  assign out_fine_x_scroll      = out_fine_x_r;
  assign out_control_zero       = out_ctrl_a_r;
  assign out_control_one        = out_ctrl_b_r;
  assign out_status_byte        = out_status_r;
  assign out_vblank_interrupt   = out_irq_r;

  // ---------------------------------------------------------------- assertions
  a_oam_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    oam_we |-> (oam_ptr_r != oam_ptr_nxt))
    else $error("sprite memory write collides with read address");

  a_status_read_clears_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && func_r == vucrf_pkg::FUNC_READ && port_r == vucrf_pkg::PORT_STATUS)
      |=> !toggle_r)
    else $error("status read left write toggle set");

  a_no_write_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |-> (out_waddr_r == '0 && out_wdata_r == '0))
    else $error("write address or data nonzero without video write");

  a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_irq_r == (out_status_r[7] & out_ctrl_a_r[7])))
    else $error("vblank interrupt disagrees with status and control");

  a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

endmodule

FILE: test/register_file_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_file_checker: result checker for the picture unit register file
// Watches the configuration, request and result channels, keeps its own copy
// of the register state, works out the result of every accepted request and
// compares each accepted result field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module register_file_checker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic        in_rendering,
  input  logic [7:0]  in_vram_rdata,
  input  logic [7:0]  in_vram_mirror_rdata,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic [14:0] out_vram_address_out,
  input  logic        out_vram_write_enable,
  input  logic [14:0] out_vram_write_address,
  input  logic [7:0]  out_vram_write_data,
  input  logic [14:0] out_scroll_latch,
  input  logic [2:0]  out_fine_x_scroll,
  input  logic [7:0]  out_control_zero,
  input  logic [7:0]  out_control_one,
  input  logic [7:0]  out_status_byte,
  input  logic        out_vblank_interrupt,

  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    logic [7:0]  read_data;
    logic [14:0] vram_address;
    logic        write_enable;
    logic [14:0] write_address;
    logic [7:0]  write_data;
    logic [14:0] scroll;
    logic [2:0]  fine_x;
    logic [7:0]  control_zero;
    logic [7:0]  control_one;
    logic [7:0]  status;
    logic        vblank_irq;
  } register_view_t;

  logic [7:0]  security_q;
  logic [7:0]  ctrl0_q, ctrl1_q, status_q, sprite_ptr_q, latch_q, buffer_q;
  logic [7:0]  sprite_mem [256];
  logic        toggle_q;
  logic [14:0] scroll_q, vaddr_q;
  logic [2:0]  fine_x_q;

  register_view_t expected_views[$];
  int mismatches = 0;

  function automatic register_view_t next_register_view(
    vucrf_pkg::func_t fn, vucrf_pkg::port_t port_in, logic [7:0] data_in, logic rendering,
    logic [7:0] vram_byte, logic [7:0] mirror_byte
  );
    register_view_t v;
    vucrf_pkg::port_t port;
    logic [7:0] byte_in;
    port = port_in;
    byte_in = data_in;
    v.write_enable = 1'b0;
    v.write_address = '0;
    v.write_data = '0;
    case (fn)
      vucrf_pkg::FUNC_WRITE: begin
        // protection part: ports 0 and 1 trade places on writes only
        if (security_q != 8'd0 && port == vucrf_pkg::PORT_CTRL0)
          port = vucrf_pkg::PORT_CTRL1;
        else if (security_q != 8'd0 && port == vucrf_pkg::PORT_CTRL1)
          port = vucrf_pkg::PORT_CTRL0;
        case (port)
          vucrf_pkg::PORT_CTRL0: begin
            ctrl0_q = byte_in;
            scroll_q[11:10] = byte_in[1:0];
          end
          vucrf_pkg::PORT_CTRL1: ctrl1_q = byte_in;
          vucrf_pkg::PORT_OAM_ADDR: sprite_ptr_q = byte_in;
          vucrf_pkg::PORT_OAM_DATA: begin
            if (rendering) byte_in = vucrf_pkg::OAM_BLANK;
            sprite_mem[sprite_ptr_q] = byte_in;
            sprite_ptr_q = sprite_ptr_q + 8'd1;
          end
          vucrf_pkg::PORT_SCROLL: begin
            if (toggle_q) begin
              scroll_q[9:5] = byte_in[7:3];
              scroll_q[14:12] = byte_in[2:0];
            end else begin
              scroll_q[4:0] = byte_in[7:3];
              fine_x_q = byte_in[2:0];
            end
            toggle_q = ~toggle_q;
          end
          vucrf_pkg::PORT_ADDR: begin
            if (toggle_q) begin
              scroll_q[7:0] = byte_in;
              vaddr_q = scroll_q;
            end else begin
              scroll_q[14:8] = {1'b0, byte_in[5:0]};
            end
            toggle_q = ~toggle_q;
          end
          vucrf_pkg::PORT_DATA: begin
            v.write_enable = 1'b1;
            v.write_address = vaddr_q;
            v.write_data = byte_in;
            vaddr_q = vaddr_q + (ctrl0_q[2] ? vucrf_pkg::STEP_ROW : vucrf_pkg::STEP_COL);
          end
          default: ;
        endcase
        latch_q = byte_in;
      end
      vucrf_pkg::FUNC_READ: begin
        case (port)
          vucrf_pkg::PORT_STATUS: begin
            if (security_q != 8'd0)
              latch_q = (status_q & vucrf_pkg::STATUS_SEC_MASK) | security_q;
            else
              latch_q = status_q | (latch_q & vucrf_pkg::LATCH_LOW_MASK);
            toggle_q = 1'b0;
            if (latch_q[7]) status_q = status_q & vucrf_pkg::STATUS_KEEP_MASK;
          end
          vucrf_pkg::PORT_OAM_DATA: latch_q = sprite_mem[sprite_ptr_q];
          vucrf_pkg::PORT_DATA: begin
            // palette page bypasses the buffer
            if (vaddr_q[13:8] == vucrf_pkg::PALETTE_PAGE) begin
              latch_q = vram_byte;
              buffer_q = mirror_byte;
            end else begin
              latch_q = buffer_q;
              buffer_q = vram_byte;
            end
            vaddr_q = vaddr_q + (ctrl0_q[2] ? vucrf_pkg::STEP_ROW : vucrf_pkg::STEP_COL);
          end
          default: ;
        endcase
      end
      vucrf_pkg::FUNC_VBLANK: status_q = status_q | vucrf_pkg::STATUS_VBLANK;
      default: status_q = status_q & vucrf_pkg::STATUS_CLEAR_MASK;
    endcase
    v.read_data = latch_q;
    v.vram_address = vaddr_q;
    v.scroll = scroll_q;
    v.fine_x = fine_x_q;
    v.control_zero = ctrl0_q;
    v.control_one = ctrl1_q;
    v.status = status_q;
    v.vblank_irq = status_q[7] & ctrl0_q[7];
    return v;
  endfunction

  task automatic report_failure(string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_failure($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    register_view_t want;
    if (!rst_n) begin
      security_q = '0;
      ctrl0_q = '0;
      ctrl1_q = '0;
      status_q = '0;
      sprite_ptr_q = '0;
      latch_q = '0;
      buffer_q = '0;
      toggle_q = 1'b0;
      scroll_q = '0;
      vaddr_q = '0;
      fine_x_q = '0;
      expected_views.delete();
    end else begin
      if (cfg_valid && cfg_ready) security_q = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          report_failure("result with no request outstanding");
        end else begin
          want = expected_views.pop_front();
          check_field("read_data", 16'(out_read_data), 16'(want.read_data));
          check_field("vram_address_out", 16'(out_vram_address_out),
                      16'(want.vram_address));
          check_field("vram_write_enable", 16'(out_vram_write_enable),
                      16'(want.write_enable));
          check_field("vram_write_address", 16'(out_vram_write_address),
                      16'(want.write_address));
          check_field("vram_write_data", 16'(out_vram_write_data), 16'(want.write_data));
          check_field("scroll_latch", 16'(out_scroll_latch), 16'(want.scroll));
          check_field("fine_x_scroll", 16'(out_fine_x_scroll), 16'(want.fine_x));
          check_field("control_zero", 16'(out_control_zero), 16'(want.control_zero));
          check_field("control_one", 16'(out_control_one), 16'(want.control_one));
          check_field("status_byte", 16'(out_status_byte), 16'(want.status));
          check_field("vblank_interrupt", 16'(out_vblank_interrupt), 16'(want.vblank_irq));
        end
      end
      if (in_valid && in_ready)
        expected_views.push_back(next_register_view(vucrf_pkg::func_t'(in_func),
          vucrf_pkg::port_t'(in_address), in_data, in_rendering, in_vram_rdata,
          in_vram_mirror_rdata));
    end
    fail_count <= mismatches;
    pending_count <= expected_views.size();
  end

endmodule

FILE: test/tb_video_unit_cpu_register_file.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_unit_cpu_register_file: testbench of the picture unit register file
// Drives directed and random bus writes, reads and status events under several
// security values, with random idling on both channels, and takes the verdict
// from the result checker.
// ----------------------------------------------------------------------------
module tb_video_unit_cpu_register_file;
  import vucrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 220;
  localparam int SWEEP_ITEMS    = 520;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  in_func;
  logic [2:0]  in_address;
  logic [7:0]  in_data;
  logic        in_rendering;
  logic [7:0]  in_vram_rdata, in_vram_mirror_rdata;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [14:0] out_vram_address_out;
  logic        out_vram_write_enable;
  logic [14:0] out_vram_write_address;
  logic [7:0]  out_vram_write_data;
  logic [14:0] out_scroll_latch;
  logic [2:0]  out_fine_x_scroll;
  logic [7:0]  out_control_zero, out_control_one, out_status_byte;
  logic        out_vblank_interrupt;

  int   fail_count, pending_count;
  int   quiet_cycles = 0;
  logic no_idle = 1'b0;

  // shadow of the sprite pointer, so no request reads a byte never written
  logic [7:0] sprite_ptr = '0;
  logic       sprite_written [256];

  video_unit_cpu_register_file uut (.*);
  register_file_checker chk (.*);

  always #5 clk = ~clk;

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 34);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_video_unit_cpu_register_file: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_request(func_t fn, port_t port, logic [7:0] data, logic rendering,
                               logic [7:0] vram_byte, logic [7:0] mirror_byte);
    port_t p;
    p = port;
    // aim a read of an unwritten sprite byte at a port with no read meaning
    if (fn == FUNC_READ && p == PORT_OAM_DATA && !sprite_written[sprite_ptr])
      p = PORT_OAM_ADDR;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_address <= p;
    in_data <= data;
    in_rendering <= rendering;
    in_vram_rdata <= vram_byte;
    in_vram_mirror_rdata <= mirror_byte;
    do @(posedge clk); while (!in_ready);
    if (fn == FUNC_WRITE && p == PORT_OAM_ADDR) begin
      sprite_ptr = data;
    end else if (fn == FUNC_WRITE && p == PORT_OAM_DATA) begin
      sprite_written[sprite_ptr] = 1'b1;
      sprite_ptr = sprite_ptr + 8'd1;
    end
  endtask

  task automatic write_port(port_t port, logic [7:0] data);
    issue_request(FUNC_WRITE, port, data, 1'($urandom_range(1)), 8'($urandom),
                  8'($urandom));
  endtask

  task automatic read_port(port_t port);
    issue_request(FUNC_READ, port, 8'($urandom), 1'($urandom_range(1)), 8'($urandom),
                  8'($urandom));
  endtask

  task automatic issue_random_request();
    int pick;
    func_t fn;
    pick = $urandom_range(99);
    if (pick < 55) fn = FUNC_WRITE;
    else if (pick < 85) fn = FUNC_READ;
    else if (pick < 93) fn = FUNC_VBLANK;
    else fn = FUNC_CLEAR;
    issue_request(fn, port_t'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                  8'($urandom), 8'($urandom));
  endtask

  // drain all results, then write the security value while the block is idle
  task automatic load_security(logic [7:0] value);
    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(int count);
    int issued;
    int kind;
    int n;
    logic [7:0] spot;
    issued = 0;
    while (issued < count) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        issue_random_request();
        issued += 1;
      end else if (kind < 70) begin
        // address setup followed by a run of data accesses
        n = $urandom_range(6, 1);
        read_port(PORT_STATUS);
        write_port(PORT_ADDR, ($urandom_range(3) == 0) ? 8'h3F : 8'($urandom));
        write_port(PORT_ADDR, 8'($urandom));
        repeat (n) begin
          if ($urandom_range(1)) write_port(PORT_DATA, 8'($urandom));
          else read_port(PORT_DATA);
        end
        issued += 3 + n;
      end else if (kind < 85) begin
        read_port(PORT_STATUS);
        write_port(PORT_SCROLL, 8'($urandom));
        write_port(PORT_SCROLL, 8'($urandom));
        issued += 3;
      end else begin
        // fill a few sprite bytes, rewind, read back the first one
        n = $urandom_range(4, 1);
        spot = 8'($urandom);
        write_port(PORT_OAM_ADDR, spot);
        repeat (n) write_port(PORT_OAM_DATA, 8'($urandom));
        write_port(PORT_OAM_ADDR, spot);
        read_port(PORT_OAM_DATA);
        issued += n + 3;
      end
    end
  endtask

  initial begin
    foreach (sprite_written[i]) sprite_written[i] = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_address = '0;
    in_data = '0;
    in_rendering = 1'b0;
    in_vram_rdata = '0;
    in_vram_mirror_rdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    load_security(8'h00);

    write_port(PORT_CTRL0, 8'h84);
    issue_request(FUNC_VBLANK, PORT_CTRL0, 8'h00, 1'b0, 8'h00, 8'h00);
    read_port(PORT_STATUS);
    issue_request(FUNC_VBLANK, PORT_DATA, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    issue_request(FUNC_CLEAR, PORT_DATA, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    write_port(PORT_CTRL1, 8'hFF);
    // sprite pointer wraps past the top, rendering forces the blank byte
    write_port(PORT_OAM_ADDR, 8'hFF);
    issue_request(FUNC_WRITE, PORT_OAM_DATA, 8'hAA, 1'b0, 8'h00, 8'h00);
    issue_request(FUNC_WRITE, PORT_OAM_DATA, 8'h55, 1'b1, 8'h00, 8'h00);
    write_port(PORT_OAM_ADDR, 8'hFF);
    read_port(PORT_OAM_DATA);
    write_port(PORT_SCROLL, 8'hFF);
    write_port(PORT_SCROLL, 8'h00);
    write_port(PORT_ADDR, 8'hFF);
    write_port(PORT_ADDR, 8'h00);
    issue_request(FUNC_READ, PORT_DATA, 8'h00, 1'b0, 8'h12, 8'h34);
    write_port(PORT_CTRL0, 8'h00);
    write_port(PORT_ADDR, 8'h00);
    write_port(PORT_ADDR, 8'h10);
    issue_request(FUNC_READ, PORT_DATA, 8'h00, 1'b0, 8'hFF, 8'h00);
    write_port(PORT_DATA, 8'hFF);
    write_port(PORT_STATUS, 8'h5A);
    read_port(PORT_CTRL0);
    read_port(PORT_SCROLL);
    read_port(PORT_ADDR);
    run_random_phase(PHASE_ITEMS);

    load_security(8'hFF);
    run_random_phase(PHASE_ITEMS);

    load_security(8'($urandom_range(254, 1)));
    no_idle = 1'b1;
    run_random_phase(PHASE_ITEMS);
    no_idle = 1'b0;

    // walk the address in row steps until it wraps past 15 bits
    load_security(8'h00);
    write_port(PORT_CTRL0, 8'h04);
    read_port(PORT_STATUS);
    write_port(PORT_ADDR, 8'h3F);
    write_port(PORT_ADDR, 8'hE0);
    repeat (SWEEP_ITEMS) begin
      if ($urandom_range(1)) write_port(PORT_DATA, 8'($urandom));
      else read_port(PORT_DATA);
    end
    run_random_phase(PHASE_ITEMS);

    load_security(8'h80);
    run_random_phase(PHASE_ITEMS);

    load_security(8'h01);
    run_random_phase(PHASE_ITEMS);

    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_video_unit_cpu_register_file: PASS");
    end else begin
      $display("tb_video_unit_cpu_register_file: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/vucrf_pkg.sv
hw/rtl/vucrf_oam.sv
hw/rtl/video_unit_cpu_register_file.sv
test/register_file_checker.sv
test/tb_video_unit_cpu_register_file.sv
